/* rtl/ir_pulse_distance_decoder_top_defines.svh */
// assertion macros for the ir pulse distance decoder
`ifndef IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IRPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpd: same-cycle check failed");
// next-cycle implication
`define IRPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpd: next-cycle check failed");
`else
`define IRPD_ASSERT_NOW(label, ante, cons)
`define IRPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/irpd_pkg.sv */
package irpd_pkg;

    // register map, word index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_FIRST_BYTE  = 2'd0,
        REG_SECOND_BYTE = 2'd1,
        REG_REPEAT_DIV  = 2'd2
    } cfg_reg_t;

    localparam logic [7:0] FIRST_BYTE_RESET  = 8'h00;
    localparam logic [7:0] SECOND_BYTE_RESET = 8'hF7;
    localparam logic [3:0] REPEAT_DIV_RESET  = 4'd4;

    // interval windows, bounds exclusive, in 100 us ticks
    localparam logic [15:0] LEADER_LO  = 16'd108;
    localparam logic [15:0] LEADER_HI  = 16'd118;
    localparam logic [15:0] REPEAT_LO  = 16'd85;
    localparam logic [15:0] REPEAT_HI  = 16'd95;
    localparam logic [15:0] RESTART_LO = 16'd100;
    localparam logic [15:0] RESTART_HI = 16'd120;
    localparam logic [15:0] ONE_LO     = 16'd14;
    localparam logic [15:0] ONE_HI     = 16'd22;

    localparam logic [8:0] CHECK_SUM = 9'd255;
    localparam logic [4:0] LAST_BIT  = 5'd31;

    typedef enum logic {
        KIND_NEW    = 1'b0,
        KIND_REPEAT = 1'b1
    } kind_t;

    function automatic logic in_window(input logic [15:0] v, input logic [15:0] lo,
                                       input logic [15:0] hi);
        in_window = (v > lo) && (v < hi);
    endfunction

endpackage

/* rtl/ir_pulse_distance_decoder_top.sv */
// IR pulse-distance remote decoder. Each input item is the tick count (100 us ticks)
// between successive falling edges of the receiver. While idle, a leader interval opens a
// frame and a repeat interval counts toward re-sending the last good command with
// kind = 1 (every repeat_divisor-th repeat; a divisor of 0 sends on every repeat).
// Inside a frame each interval is a data bit (one-bit window gives 1, else 0), shifted
// in msb first; a restart-window interval clears the assembler. After FRAME_EDGES
// intervals, leader included, the frame closes and the last complete 32-bit word is
// checked: bytes 3 and 2 against the configured address bytes, bytes 1 and 0 must sum
// to 255. A pass gives one result item with the command byte and kind = 0; a frame
// with no fresh word re-checks the previous one. Throughput is one item per clock;
// an item is taken into an input register and decoded from there into the result
// register whenever that register is free or being drained. A result held by
// m_tready low holds the item behind it in the input register, and s_tready drops
// once that register is full. Registers (APB, 32-bit words):
// 0x0 first_byte_expected, 0x4 second_byte_expected, 0x8 repeat_divisor; write them
// only while no item is in flight.
`include "ir_pulse_distance_decoder_top_defines.svh"

module ir_pulse_distance_decoder_top #(
    parameter int FRAME_EDGES = 33
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // interval items in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] interval_ticks
    // decoded items out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] command
    output logic [0:0]  m_tuser    // [0] kind
);

    localparam int EDGE_W = $clog2(FRAME_EDGES + 1);

    // configuration registers
    logic [7:0] first_byte_reg;
    logic [7:0] second_byte_reg;
    logic [3:0] repeat_div_reg;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_ticks_reg;

    // decoder state
    logic              frame_open_reg, frame_open_next;
    logic [EDGE_W-1:0] edges_reg, edges_next;
    logic              active_reg, active_next;
    logic [4:0]        bits_reg, bits_next;
    logic [31:0]       shift_reg, shift_next;
    logic [31:0]       latched_reg, latched_next;
    logic [7:0]        last_cmd_reg, last_cmd_next;
    logic [3:0]        tally_reg, tally_next;

    // result register
    logic                out_valid_reg;
    logic [7:0]          out_cmd_reg;
    irpd_pkg::kind_t     out_kind_reg;

    // decode results of the item in the input register
    logic              advance;
    logic              emit;
    logic [7:0]        emit_cmd;
    irpd_pkg::kind_t   emit_kind;
    logic              is_leader, is_repeat, is_restart, is_one;
    logic [31:0]       shifted;
    logic [31:0]       check_word;
    logic [EDGE_W-1:0] edges_inc;
    logic [3:0]        tally_inc;
    logic [8:0]        byte_sum;
    logic              word_ok;
    logic              cfg_write;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_byte_reg  <= irpd_pkg::FIRST_BYTE_RESET;
            second_byte_reg <= irpd_pkg::SECOND_BYTE_RESET;
            repeat_div_reg  <= irpd_pkg::REPEAT_DIV_RESET;
        end
        else if (cfg_write)
        begin
            case (irpd_pkg::cfg_reg_t'(paddr[3:2]))
                irpd_pkg::REG_FIRST_BYTE:  first_byte_reg  <= pwdata[7:0];
                irpd_pkg::REG_SECOND_BYTE: second_byte_reg <= pwdata[7:0];
                irpd_pkg::REG_REPEAT_DIV:  repeat_div_reg  <= pwdata[3:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (irpd_pkg::cfg_reg_t'(paddr[3:2]))
            irpd_pkg::REG_FIRST_BYTE:  prdata = {24'd0, first_byte_reg};
            irpd_pkg::REG_SECOND_BYTE: prdata = {24'd0, second_byte_reg};
            irpd_pkg::REG_REPEAT_DIV:  prdata = {28'd0, repeat_div_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    // the decode stage moves whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ticks_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------- decode
    assign is_leader  = irpd_pkg::in_window(in_ticks_reg, irpd_pkg::LEADER_LO,
                                            irpd_pkg::LEADER_HI);
    assign is_repeat  = irpd_pkg::in_window(in_ticks_reg, irpd_pkg::REPEAT_LO,
                                            irpd_pkg::REPEAT_HI);
    assign is_restart = irpd_pkg::in_window(in_ticks_reg, irpd_pkg::RESTART_LO,
                                            irpd_pkg::RESTART_HI);
    assign is_one     = irpd_pkg::in_window(in_ticks_reg, irpd_pkg::ONE_LO,
                                            irpd_pkg::ONE_HI);

    assign shifted   = {shift_reg[30:0], is_one};
    assign edges_inc = edges_reg + EDGE_W'(1);
    assign tally_inc = tally_reg + 4'd1;

    // the check sees a word latched by this very item, else the one latched before
    assign check_word = (active_reg && !is_restart && (bits_reg == irpd_pkg::LAST_BIT))
                      ? shifted : latched_reg;
    assign byte_sum = {1'b0, check_word[15:8]} + {1'b0, check_word[7:0]};
    assign word_ok  = (check_word[31:24] == first_byte_reg)
                   && (check_word[23:16] == second_byte_reg)
                   && (byte_sum == irpd_pkg::CHECK_SUM);

    always_comb
    begin
        frame_open_next = frame_open_reg;
        edges_next      = edges_reg;
        active_next     = active_reg;
        bits_next       = bits_reg;
        shift_next      = shift_reg;
        latched_next    = latched_reg;
        last_cmd_next   = last_cmd_reg;
        tally_next      = tally_reg;
        emit            = 1'b0;
        emit_cmd        = last_cmd_reg;
        emit_kind       = irpd_pkg::KIND_NEW;

        if (advance)
        begin
            if (!frame_open_reg)
            begin
                if (is_leader)
                begin
                    // leader opens the frame and restarts the assembler
                    frame_open_next = 1'b1;
                    edges_next      = EDGE_W'(1);
                    active_next     = 1'b1;
                    bits_next       = 5'd0;
                    shift_next      = 32'd0;
                end
                else if (is_repeat)
                begin
                    bits_next = 5'd0;
                    if (tally_inc < repeat_div_reg)
                    begin
                        tally_next = tally_inc;
                    end
                    else
                    begin
                        tally_next = 4'd0;
                        emit       = 1'b1;
                        emit_kind  = irpd_pkg::KIND_REPEAT;
                    end
                end
            end
            else
            begin
                // bit assembler
                if (is_restart)
                begin
                    active_next = 1'b1;
                    bits_next   = 5'd0;
                    shift_next  = 32'd0;
                end
                else if (active_reg)
                begin
                    if (bits_reg == irpd_pkg::LAST_BIT)
                    begin
                        latched_next = shifted;
                        shift_next   = 32'd0;
                        bits_next    = 5'd0;
                        active_next  = 1'b0;
                    end
                    else
                    begin
                        shift_next = shifted;
                        bits_next  = bits_reg + 5'd1;
                    end
                end
                else
                begin
                    shift_next = 32'd0;
                    bits_next  = 5'd0;
                end

                // frame length and end-of-frame check
                if (edges_inc < EDGE_W'(FRAME_EDGES))
                begin
                    edges_next = edges_inc;
                end
                else
                begin
                    frame_open_next = 1'b0;
                    edges_next      = '0;
                    tally_next      = 4'd0;
                    if (word_ok)
                    begin
                        last_cmd_next = check_word[15:8];
                        emit          = 1'b1;
                        emit_cmd      = check_word[15:8];
                        emit_kind     = irpd_pkg::KIND_NEW;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            edges_reg      <= '0;
            active_reg     <= 1'b0;
            bits_reg       <= 5'd0;
            shift_reg      <= 32'd0;
            latched_reg    <= 32'd0;
            last_cmd_reg   <= 8'd0;
            tally_reg      <= 4'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            edges_reg      <= edges_next;
            active_reg     <= active_next;
            bits_reg       <= bits_next;
            shift_reg      <= shift_next;
            latched_reg    <= latched_next;
            last_cmd_reg   <= last_cmd_next;
            tally_reg      <= tally_next;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_cmd_reg  <= emit_cmd;
            out_kind_reg <= emit_kind;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_cmd_reg;
    assign m_tuser[0] = out_kind_reg;

    // ---------------------------------------------------------------- checks
    // edge count only runs inside a frame
    `IRPD_ASSERT_NOW(a_edges_idle, !frame_open_reg, edges_reg == '0)
    // an idle assembler holds no partial bit count
    `IRPD_ASSERT_NOW(a_bits_idle, !active_reg, bits_reg == 5'd0)
    // a pending new-press result is the remembered command
    `IRPD_ASSERT_NOW(a_cmd_kept, m_tvalid && !m_tuser[0], m_tdata == last_cmd_reg)
    // an accepted item lands in the input register
    `IRPD_ASSERT_NEXT(a_in_loaded, s_tvalid && s_tready, in_valid_reg)

endmodule

/* dv/tb_ir_pulse_distance_decoder_top.sv */
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder_top;

    localparam int FRAME_LEN    = 33;     // intervals per frame, leader included
    localparam int PHASES       = 8;
    localparam int ITEMS_PHASE  = 240;    // counted items per phase, ignored noise aside
    localparam int SETTLE       = 12;     // input and result registers plus margin
    localparam int CYCLE_LIMIT  = 400000; // hang bound, far above the slowest run

    // decoded result as the block should send it
    typedef struct {
        logic [7:0]      command;
        irpd_pkg::kind_t kind;
    } decode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] interval_ticks
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] command
    logic [0:0]  m_tuser;        // [0] kind

    // pending intervals and decodes still owed by the block
    logic [15:0] interval_q[$];
    decode_t     decodes_due[$];

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          counted_items = 0;
    int          cycle_count = 0;

    // decoder mirror: configuration
    logic [7:0]  addr_hi_cfg = irpd_pkg::FIRST_BYTE_RESET;
    logic [7:0]  addr_lo_cfg = irpd_pkg::SECOND_BYTE_RESET;
    logic [3:0]  rpt_div_cfg = irpd_pkg::REPEAT_DIV_RESET;

    // decoder mirror: state
    logic        frame_open = 1'b0;
    logic [5:0]  edge_count = '0;
    logic        asm_on = 1'b0;
    logic [5:0]  bit_count = '0;
    logic [31:0] shift_reg = '0;
    logic [31:0] word_latch = '0;
    logic [7:0]  last_cmd = '0;
    logic [3:0]  rpt_count = '0;

    ir_pulse_distance_decoder_top #(
        .FRAME_EDGES(FRAME_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // open window, both bounds excluded
    function automatic logic in_range(input logic [15:0] v, input logic [15:0] lo,
                                      input logic [15:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    // bit assembler: restart window clears it, an active one shifts msb first
    function automatic void assemble_bit(input logic [15:0] t);
        if (in_range(t, irpd_pkg::RESTART_LO, irpd_pkg::RESTART_HI))
        begin
            asm_on    = 1'b1;
            bit_count = '0;
            shift_reg = '0;
        end
        else if (asm_on)
        begin
            shift_reg = {shift_reg[30:0], in_range(t, irpd_pkg::ONE_LO, irpd_pkg::ONE_HI)};
            bit_count = bit_count + 6'd1;
            if (bit_count > 6'd31)
            begin
                word_latch = shift_reg;
                shift_reg  = '0;
                bit_count  = '0;
                asm_on     = 1'b0;
            end
        end
        else
        begin
            // assembler parked after a full word
            shift_reg = '0;
            bit_count = '0;
        end
    endfunction

    // advance the mirror by one accepted interval, queue any decode it yields
    function automatic void decode_interval(input logic [15:0] t);
        decode_t d;
        logic [8:0] sum;
        if (!frame_open)
        begin
            if (in_range(t, irpd_pkg::LEADER_LO, irpd_pkg::LEADER_HI))
            begin
                frame_open = 1'b1;
                edge_count = 6'd1;
                assemble_bit(t);
            end
            else if (in_range(t, irpd_pkg::REPEAT_LO, irpd_pkg::REPEAT_HI))
            begin
                bit_count = '0;
                rpt_count = rpt_count + 4'd1;
                // a divisor of zero fires on every repeat
                if (rpt_count >= rpt_div_cfg)
                begin
                    rpt_count = '0;
                    d.command = last_cmd;
                    d.kind    = irpd_pkg::KIND_REPEAT;
                    decodes_due.push_back(d);
                end
            end
        end
        else
        begin
            assemble_bit(t);
            edge_count = edge_count + 6'd1;
            if (edge_count >= FRAME_LEN)
            begin
                // frame closes; the latched word may be stale
                frame_open = 1'b0;
                edge_count = '0;
                rpt_count  = '0;
                sum = {1'b0, word_latch[15:8]} + {1'b0, word_latch[7:0]};
                if (word_latch[31:24] == addr_hi_cfg && word_latch[23:16] == addr_lo_cfg
                    && sum == irpd_pkg::CHECK_SUM)
                begin
                    last_cmd  = word_latch[15:8];
                    d.command = word_latch[15:8];
                    d.kind    = irpd_pkg::KIND_NEW;
                    decodes_due.push_back(d);
                end
            end
        end
    endfunction

    // interval driver: holds valid until taken, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_interval(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (interval_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= interval_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: compare each taken item with the oldest decode owed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decodes_due.size() == 0)
                begin
                    $error("unexpected item: command %0h kind %0d", m_tdata, m_tuser[0]);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    decode_t d;
                    d = decodes_due.pop_front();
                    if (m_tdata !== d.command)
                    begin
                        $error("command: expected %0h, got %0h", d.command, m_tdata);
                        mismatches = mismatches + 1;
                    end
                    if (m_tuser[0] !== d.kind)
                    begin
                        $error("kind: expected %0d, got %0d", d.kind, m_tuser[0]);
                        mismatches = mismatches + 1;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // zero-bit interval: nominal half the time, otherwise far off or on a window edge
    function automatic logic [15:0] zero_ticks();
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'($urandom_range(65535));
            1: v = irpd_pkg::ONE_LO;
            2: v = irpd_pkg::ONE_HI;
            3: v = irpd_pkg::RESTART_LO;
            4: v = irpd_pkg::RESTART_HI;
            default: v = 16'($urandom_range(13));
        endcase
        // keep clear of the one and restart windows
        if (in_range(v, irpd_pkg::ONE_LO, irpd_pkg::ONE_HI)
            || in_range(v, irpd_pkg::RESTART_LO, irpd_pkg::RESTART_HI))
            v = 16'd11;
        return v;
    endfunction

    // any interval, biased to the interesting range
    function automatic logic [15:0] any_ticks();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(130));
    endfunction

    // leader plus 32 bits msb first; a nonzero cut puts a restart at that bit slot
    task automatic push_frame(input logic [31:0] word, input int cut);
        interval_q.push_back(16'($urandom_range(irpd_pkg::LEADER_LO + 1,
                                                irpd_pkg::LEADER_HI - 1)));
        for (int i = 31; i >= 0; i--)
        begin
            if (cut != 0 && i == 32 - cut)
                interval_q.push_back(16'($urandom_range(irpd_pkg::RESTART_LO + 1,
                                                        irpd_pkg::RESTART_HI - 1)));
            else if (word[i])
                interval_q.push_back(16'($urandom_range(irpd_pkg::ONE_LO + 1,
                                                        irpd_pkg::ONE_HI - 1)));
            else
                interval_q.push_back(zero_ticks());
        end
        counted_items += FRAME_LEN;
    endtask

    // address bytes mostly right, command/inverse pair mostly consistent
    function automatic logic [31:0] frame_word();
        logic [7:0] a0, a1, c, n;
        a0 = ($urandom_range(99) < 85) ? addr_hi_cfg : 8'($urandom);
        a1 = ($urandom_range(99) < 85) ? addr_lo_cfg : 8'($urandom);
        c  = 8'($urandom);
        n  = ($urandom_range(99) < 85) ? ~c : 8'($urandom);
        return {a0, a1, c, n};
    endfunction

    // APB write with setup and access phases, only while the decoder is idle
    task automatic write_reg(input irpd_pkg::cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            irpd_pkg::REG_FIRST_BYTE:  addr_hi_cfg = val[7:0];
            irpd_pkg::REG_SECOND_BYTE: addr_lo_cfg = val[7:0];
            irpd_pkg::REG_REPEAT_DIV:  rpt_div_cfg = val[3:0];
            default: ;
        endcase
    endtask

    // all items taken and all decodes seen, then let the pipe empty
    task automatic wait_drained();
        while (interval_q.size() != 0 || s_tvalid || decodes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] hi_sel[PHASES];
        logic [7:0] lo_sel[PHASES];
        logic [3:0] div_sel[PHASES];
        int n;

        // settings per phase: reset values, the extremes, a mixed pattern, then random
        hi_sel  = '{irpd_pkg::FIRST_BYTE_RESET, 8'hFF, 8'h00, 8'hA5,
                    8'h00, 8'h00, 8'h00, 8'h00};
        lo_sel  = '{irpd_pkg::SECOND_BYTE_RESET, 8'h00, 8'hFF, 8'h5A,
                    8'h00, 8'h00, 8'h00, 8'h00};
        div_sel = '{irpd_pkg::REPEAT_DIV_RESET, 4'd1, 4'd15, 4'd0,
                    4'd0, 4'd0, 4'd0, 4'd0};
        for (int p = 4; p < PHASES; p++)
        begin
            hi_sel[p]  = 8'($urandom);
            lo_sel[p]  = 8'($urandom);
            div_sel[p] = 4'($urandom_range(15));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            if (p != 0)
            begin
                write_reg(irpd_pkg::REG_FIRST_BYTE, {24'd0, hi_sel[p]});
                write_reg(irpd_pkg::REG_SECOND_BYTE, {24'd0, lo_sel[p]});
                write_reg(irpd_pkg::REG_REPEAT_DIV, {28'd0, div_sel[p]});
            end

            // no idling, sender gaps, receiver stalls, both
            case (p % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_gap_pct   = 16;
                    recv_stall_pct = 16;
                end
            endcase

            if (p == 0)
            begin
                // idle: field extremes and window edges are ignored,
                // then four repeats send the reset command as a repeat
                interval_q = '{16'd0, 16'hFFFF,
                               irpd_pkg::LEADER_LO, irpd_pkg::LEADER_HI,
                               irpd_pkg::REPEAT_LO, irpd_pkg::REPEAT_HI,
                               irpd_pkg::RESTART_LO, irpd_pkg::RESTART_HI,
                               16'h5555, 16'hAAAA,
                               16'd86, 16'd94, 16'd90, 16'd89};
                counted_items += 14;
            end

            while (counted_items < (p + 1) * ITEMS_PHASE)
            begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                        push_frame(frame_word(), 0);
                    11, 12, 13:
                    begin
                        // held key: a burst of repeat intervals
                        n = $urandom_range(1, 18);
                        for (int i = 0; i < n; i++)
                            interval_q.push_back(16'($urandom_range(irpd_pkg::REPEAT_LO + 1,
                                                                    irpd_pkg::REPEAT_HI - 1)));
                        counted_items += n;
                    end
                    14, 15:
                        // restart mid-frame leaves the word incomplete
                        push_frame(frame_word(), $urandom_range(1, 32));
                    16, 17:
                    begin
                        // leader followed by garbage intervals
                        interval_q.push_back(16'($urandom_range(irpd_pkg::LEADER_LO + 1,
                                                                irpd_pkg::LEADER_HI - 1)));
                        for (int i = 0; i < 32; i++)
                            interval_q.push_back(any_ticks());
                        counted_items += FRAME_LEN;
                    end
                    default:
                    begin
                        // line noise, may knock the frame alignment off
                        n = $urandom_range(1, 3);
                        for (int i = 0; i < n; i++)
                            interval_q.push_back(any_ticks());
                    end
                endcase
            end
        end

        wait_drained();
        if (mismatches == 0 && decodes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
